[sv/cylindrical_warp_coordinate_map_defines.svh]
// Assertion macros for the cylindrical warp coordinate mapper.
// Included by the top level; no other dependencies.
`ifndef CYLINDRICAL_WARP_COORDINATE_MAP_DEFINES_SVH
`define CYLINDRICAL_WARP_COORDINATE_MAP_DEFINES_SVH
`ifndef SYNTH
`define CWCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cwcm assertion failed");
`define CWCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwcm assertion failed");
`else
`define CWCM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CWCM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/cwcm_pkg.sv]
// Shared constants, types and the arctangent step table of the warp mapper.
// No dependencies.
package cwcm_pkg;

   localparam int CORDIC_WIDTH  = 32;
   localparam int CORDIC_GUARD  = 8;
   localparam int FOCAL_BITS    = 20;
   localparam int PIXEL_BITS    = 24;
   localparam int COL_BITS      = 18;
   localparam int ROW_GAIN      = 53961;
   localparam int ROW_GAIN_BITS = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_FOCAL_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [COL_BITS-1:0] col;
      logic [PIXEL_BITS-1:0]      pixel;
      logic                       neg;
      logic                       mag_zero;
   } cwcm_side_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [29:0] atan_step_q30(input int idx);
      logic [29:0] v;
      v = '0;
      case (idx)
         0:  v = 30'd843314856;
         1:  v = 30'd497837829;
         2:  v = 30'd263043836;
         3:  v = 30'd133525158;
         4:  v = 30'd67021686;
         5:  v = 30'd33543515;
         6:  v = 30'd16775850;
         7:  v = 30'd8388437;
         8:  v = 30'd4194282;
         9:  v = 30'd2097149;
         10: v = 30'd1048575;
         11: v = 30'd524287;
         12: v = 30'd262143;
         13: v = 30'd131071;
         14: v = 30'd65535;
         15: v = 30'd32767;
         16: v = 30'd16383;
         17: v = 30'd8191;
         18: v = 30'd4095;
         19: v = 30'd2047;
         20: v = 30'd1023;
         21: v = 30'd511;
         22: v = 30'd255;
         23: v = 30'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[sv/cwcm_if.sv]
// Request and result channel interfaces of the warp mapper.
// Depends on cwcm_pkg.
interface cwcm_req_if #(parameter int COORD_BITS = 11);
   import cwcm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] source_row;
   logic [COORD_BITS-1:0] source_column;
   logic [PIXEL_BITS-1:0] pixel_value;
   modport source (output valid, source_row, source_column, pixel_value, input ready);
   modport sink (input valid, source_row, source_column, pixel_value, output ready);
endinterface

interface cwcm_rsp_if #(parameter int COORD_BITS = 11);
   import cwcm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] dest_row;
   logic [COORD_BITS-1:0] dest_column;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  in_range;
   modport source (output valid, dest_row, dest_column, pixel_out, in_range, input ready);
   modport sink (input valid, dest_row, dest_column, pixel_out, in_range, output ready);
endinterface

[sv/cwcm_cordic_stage.sv]
// One registered iteration of the vectoring CORDIC.
// Depends on cwcm_pkg for the datapath width and the atan step table.
module cwcm_cordic_stage #(
   parameter int IDX = 0,
   parameter int AFB = 16,
   parameter int ZW  = 18
) (
   input  logic                                     clock,
   input  logic                                     adv,
   input  logic signed [cwcm_pkg::CORDIC_WIDTH-1:0] x_i,
   input  logic signed [cwcm_pkg::CORDIC_WIDTH-1:0] y_i,
   input  logic signed [ZW-1:0]                     z_i,
   output logic signed [cwcm_pkg::CORDIC_WIDTH-1:0] x_o,
   output logic signed [cwcm_pkg::CORDIC_WIDTH-1:0] y_o,
   output logic signed [ZW-1:0]                     z_o
);
   import cwcm_pkg::*;

   localparam logic signed [ZW-1:0] STEP = ZW'(atan_step_q30(IDX) >> (30 - AFB));

   logic signed [CORDIC_WIDTH-1:0] xs, ys;
   logic signed [CORDIC_WIDTH-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [ZW-1:0]           z_in, z_ff;

   assign xs = x_i >>> IDX;
   assign ys = y_i >>> IDX;

   always_comb begin
      if (!y_i[CORDIC_WIDTH-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + STEP;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

[sv/cwcm_div_stage.sv]
// One registered quotient bit of the restoring divider for the row.
// Depends on cwcm_pkg for the side payload type.
module cwcm_div_stage #(
   parameter int RW  = 52,
   parameter int DW  = 38,
   parameter int QB  = 14,
   parameter int BIT = 0
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [RW-1:0]           rem_i,
   input  logic [DW-1:0]           den_i,
   input  logic [QB-1:0]           quo_i,
   input  cwcm_pkg::cwcm_side_type side_i,
   output logic [RW-1:0]           rem_o,
   output logic [DW-1:0]           den_o,
   output logic [QB-1:0]           quo_o,
   output cwcm_pkg::cwcm_side_type side_o
);
   import cwcm_pkg::*;

   logic [RW:0]    trial;
   logic [RW-1:0]  rem_in, rem_ff;
   logic [QB-1:0]  quo_in, quo_ff;
   logic [DW-1:0]  den_ff;
   cwcm_side_type  side_ff;

   assign trial = {1'b0, rem_i} - ((RW + 1)'(den_i) << BIT);

   always_comb begin
      quo_in      = quo_i;
      quo_in[BIT] = ~trial[RW];
      rem_in      = trial[RW] ? rem_i : trial[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_i;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign quo_o  = quo_ff;
   assign side_o = side_ff;

endmodule

[sv/cylindrical_warp_coordinate_map.sv]
// Top level of the cylindrical warp coordinate mapper: CSR block and pipeline.
// Depends on cwcm_pkg, cwcm_if, cwcm_cordic_stage, cwcm_div_stage and the defines header.
// Takes one request per clock while the result is not stalled and returns one result per
// request, in order. The pipeline is one front register, one stage per CORDIC iteration
// (two lanes side by side, one for the pixel, one for the half-width reference angle),
// two multiply/round stages, one stage per row quotient bit (COORD_BITS + 3 of them) and
// an output register. A stalled result holds the whole pipeline. Registers may be written
// only while no request is in flight.
`include "cylindrical_warp_coordinate_map_defines.svh"
module cylindrical_warp_coordinate_map #(
   parameter int COORD_BITS      = 11,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cwcm_req_if.sink                             req_bus,
   cwcm_rsp_if.source                           rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cwcm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [cwcm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [cwcm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import cwcm_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int A      = ANGLE_FRAC_BITS;
   localparam int CW     = CORDIC_WIDTH;
   localparam int DXW    = C + 2;
   localparam int ZW     = A + 2;
   localparam int SW     = A + 3;
   localparam int QB     = C + 3;
   localparam int FKW    = FOCAL_BITS + ROW_GAIN_BITS;
   localparam int RPW    = FKW + 1 + DXW;
   localparam int NW     = RPW + 1;
   localparam int HMW    = C + CW;
   localparam int HM_SH  = 6;
   localparam int DEN_SH = 7;
   localparam int DW     = CW - 1 + DEN_SH;
   localparam int RW     = DW + QB;
   localparam int CPW    = FOCAL_BITS + 1 + SW;
   localparam int XSH    = 1 + CORDIC_GUARD;
   localparam int YSH    = 6 + CORDIC_GUARD;
   localparam int LAT    = A + QB + 4;

   localparam logic signed [CPW-1:0] COL_RND = CPW'(1) << (A + 5);

   // ---------------- registers ----------------
   logic [C-1:0]          frame_w_ff, frame_h_ff;
   logic [FOCAL_BITS-1:0] focal_ff;
   logic [FKW-1:0]        focal_k_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= C'(1280);
         frame_h_ff <= C'(720);
         focal_ff   <= FOCAL_BITS'(94593);
      end else if (psel && penable && pwrite) begin
         unique case (csr_index_type'(paddr[3:2]))
            REG_FRAME_WIDTH:  frame_w_ff <= pwdata[C-1:0];
            REG_FRAME_HEIGHT: frame_h_ff <= pwdata[C-1:0];
            REG_FOCAL_LENGTH: focal_ff   <= pwdata[FOCAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index_type'(paddr[3:2]))
         REG_FRAME_WIDTH:  prdata = CSR_DATA_BITS'(frame_w_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_BITS'(frame_h_ff);
         REG_FOCAL_LENGTH: prdata = CSR_DATA_BITS'(focal_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      focal_k_ff <= FKW'(focal_ff) * FKW'(ROW_GAIN);
   end

   // ---------------- pipeline control ----------------
   logic [LAT-1:0] v_ff, v_in;
   logic           adv;

   assign adv           = !v_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign v_in          = {v_ff[LAT-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // ---------------- front stage ----------------
   logic signed [DXW-1:0]        dx_in, dy_in;
   logic signed [CW-1:0]         x0_ff, py0_ff, ry0_ff;
   logic signed [DXW-1:0]        dy_ff [0:A];
   logic [PIXEL_BITS-1:0]        pix_ff [0:A];

   assign dx_in = $signed({1'b0, req_bus.source_column, 1'b0} - {2'b00, frame_w_ff});
   assign dy_in = $signed({1'b0, req_bus.source_row, 1'b0} - {2'b00, frame_h_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff     <= $signed(CW'(focal_ff) << XSH);
         py0_ff    <= CW'(dx_in) <<< YSH;
         ry0_ff    <= $signed(CW'(frame_w_ff) << YSH);
         dy_ff[0]  <= dy_in;
         pix_ff[0] <= req_bus.pixel_value;
         for (int k = 1; k <= A; k++) begin
            dy_ff[k]  <= dy_ff[k-1];
            pix_ff[k] <= pix_ff[k-1];
         end
      end
   end

   // ---------------- CORDIC ----------------
   logic signed [CW-1:0] px_w [0:A];
   logic signed [CW-1:0] py_w [0:A];
   logic signed [ZW-1:0] pz_w [0:A];
   logic signed [CW-1:0] rx_w [0:A];
   logic signed [CW-1:0] ry_w [0:A];
   logic signed [ZW-1:0] rz_w [0:A];

   assign px_w[0] = x0_ff;
   assign py_w[0] = py0_ff;
   assign pz_w[0] = '0;
   assign rx_w[0] = x0_ff;
   assign ry_w[0] = ry0_ff;
   assign rz_w[0] = '0;

   for (genvar k = 0; k < A; k++) begin : g_cordic
      cwcm_cordic_stage #(.IDX(k), .AFB(A), .ZW(ZW)) u_pix (
         .clock (clock), .adv (adv),
         .x_i (px_w[k]), .y_i (py_w[k]), .z_i (pz_w[k]),
         .x_o (px_w[k+1]), .y_o (py_w[k+1]), .z_o (pz_w[k+1])
      );
      cwcm_cordic_stage #(.IDX(k), .AFB(A), .ZW(ZW)) u_ref (
         .clock (clock), .adv (adv),
         .x_i (rx_w[k]), .y_i (ry_w[k]), .z_i (rz_w[k]),
         .x_o (rx_w[k+1]), .y_o (ry_w[k+1]), .z_o (rz_w[k+1])
      );
   end

   // ---------------- multiply stage ----------------
   logic signed [SW-1:0]  zsum;
   logic signed [CPW-1:0] colprod_ff;
   logic signed [RPW-1:0] rowprod_ff;
   logic [HMW-1:0]        hm_ff;
   logic [CW-2:0]         mag_ff;
   logic                  magz_ff;
   logic [PIXEL_BITS-1:0] pix_m_ff;
   logic [C:0]            h_inc;

   assign zsum  = SW'(pz_w[A]) + SW'(rz_w[A]);
   assign h_inc = {1'b0, frame_h_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (adv) begin
         colprod_ff <= $signed({1'b0, focal_ff}) * zsum;
         rowprod_ff <= $signed({1'b0, focal_k_ff}) * dy_ff[A];
         hm_ff      <= HMW'(h_inc) * HMW'(px_w[A][CW-2:0]);
         mag_ff     <= px_w[A][CW-2:0];
         magz_ff    <= px_w[A][CW-1] || (px_w[A] == '0);
         pix_m_ff   <= pix_ff[A];
      end
   end

   // ---------------- round / prepare divide ----------------
   logic signed [CPW-1:0] colsum;
   logic signed [NW-1:0]  numer;
   logic                  neg;
   logic [NW-2:0]         nabs;
   logic [RW-1:0]         rem_w  [0:QB];
   logic [DW-1:0]         den_w  [0:QB];
   logic [QB-1:0]         quo_w  [0:QB];
   cwcm_side_type         side_w [0:QB];
   logic [RW-1:0]         rem0_ff;
   logic [DW-1:0]         den0_ff;
   cwcm_side_type         side0_ff;

   assign colsum = colprod_ff + COL_RND;
   assign numer  = NW'(rowprod_ff) + $signed(NW'({1'b0, hm_ff}) << HM_SH);
   assign neg    = numer[NW-1];
   assign nabs   = neg ? ~numer[NW-2:0] : numer[NW-2:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem0_ff           <= RW'(nabs);
         den0_ff           <= DW'(mag_ff) << DEN_SH;
         side0_ff.col      <= COL_BITS'(colsum >>> (A + 6));
         side0_ff.pixel    <= pix_m_ff;
         side0_ff.neg      <= neg;
         side0_ff.mag_zero <= magz_ff;
      end
   end

   assign rem_w[0]  = rem0_ff;
   assign den_w[0]  = den0_ff;
   assign quo_w[0]  = '0;
   assign side_w[0] = side0_ff;

   // ---------------- divider ----------------
   for (genvar k = 0; k < QB; k++) begin : g_div
      cwcm_div_stage #(.RW(RW), .DW(DW), .QB(QB), .BIT(QB - 1 - k)) u_div (
         .clock (clock), .adv (adv),
         .rem_i (rem_w[k]), .den_i (den_w[k]), .quo_i (quo_w[k]), .side_i (side_w[k]),
         .rem_o (rem_w[k+1]), .den_o (den_w[k+1]), .quo_o (quo_w[k+1]),
         .side_o (side_w[k+1])
      );
   end

   // ---------------- output stage ----------------
   logic signed [QB:0]        qs, row_div, row_half, row;
   logic signed [COL_BITS-1:0] col;
   logic                      ok;
   logic [C-1:0]              orow_ff, ocol_ff;
   logic [PIXEL_BITS-1:0]     opix_ff;
   logic                      ook_ff;

   assign qs       = $signed({1'b0, quo_w[QB]});
   assign row_div  = side_w[QB].neg ? ~qs : qs;
   assign row_half = $signed((QB + 1)'(h_inc >> 1));
   assign row      = side_w[QB].mag_zero ? row_half : row_div;
   assign col      = side_w[QB].col;
   assign ok       = !col[COL_BITS-1] && (col[COL_BITS-2:0] < (COL_BITS - 1)'(frame_w_ff))
                     && !row[QB] && (row[QB-1:0] < QB'(frame_h_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         orow_ff <= ok ? row[C-1:0] : '0;
         ocol_ff <= ok ? col[C-1:0] : '0;
         opix_ff <= side_w[QB].pixel;
         ook_ff  <= ok;
      end
   end

   assign rsp_bus.valid       = v_ff[LAT-1];
   assign rsp_bus.dest_row    = orow_ff;
   assign rsp_bus.dest_column = ocol_ff;
   assign rsp_bus.pixel_out   = opix_ff;
   assign rsp_bus.in_range    = ook_ff;

   // ---------------- assertions ----------------
   `CWCM_ASSERT_NEXT(a_stall_holds_valids, clock, reset, !adv, $stable(v_ff))
   `CWCM_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_bus.valid && req_bus.ready, v_ff[0])
   `CWCM_ASSERT_IMPLY(a_drop_zeroes_coords, clock, reset, rsp_bus.valid && !rsp_bus.in_range, rsp_bus.dest_row == '0 && rsp_bus.dest_column == '0)

endmodule
